// ----- rtl/box_muller_gaussian_noise_top_macros.svh -----
// assertion helpers shared by the noise generator modules
// every use expects clk_i and rst_ni in scope
`ifndef BOX_MULLER_GAUSSIAN_NOISE_TOP_MACROS_SVH
`define BOX_MULLER_GAUSSIAN_NOISE_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define BMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BMG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/bmg_pkg.sv -----
`timescale 1ns / 1ps
package bmg_pkg;

  // default sizes
  localparam int UNIFORM_BITS_DEF  = 53;
  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // fixed arithmetic widths
  localparam int FRAC_W = 53;
  localparam int PH_W   = 32;
  localparam int ROOT_W = 28;
  localparam int RAD_W  = 2 * ROOT_W;

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  localparam logic [30:0] THRESHOLD_RST = 31'd2;

  // horner steps: cosine divisors first, then sine divisors
  localparam int NUM_K = 11;
  localparam logic [3:0] COS_LAST = 4'd5;
  localparam logic [3:0] SIN_LAST = 4'd10;

  // reciprocal m = ceil(2^(30+l)/k) with l = ceil(log2 k), exact for 30-bit dividends
  localparam logic [31:0] RECIP_TBL [NUM_K] = '{
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89)  / 64'd90),
    32'(((64'd1 << 36) + 64'd55)  / 64'd56),
    32'(((64'd1 << 35) + 64'd29)  / 64'd30),
    32'(((64'd1 << 34) + 64'd11)  / 64'd12),
    32'(((64'd1 << 31) + 64'd1)   / 64'd2),
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71)  / 64'd72),
    32'(((64'd1 << 36) + 64'd41)  / 64'd42),
    32'(((64'd1 << 35) + 64'd19)  / 64'd20),
    32'(((64'd1 << 33) + 64'd5)   / 64'd6)
  };

  // extra right shift l beyond 30 for each divisor
  localparam logic [3:0] RSHIFT_TBL [NUM_K] = '{
    4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd1, 4'd7, 4'd7, 4'd6, 4'd5, 4'd3
  };

  // one pair of uniforms handed from front to back
  typedef struct packed {
    logic [FRAC_W-1:0] u1;
    logic [PH_W-1:0]   ph;
  } pair_t;

endpackage

// ----- rtl/bmg_front.sv -----
`timescale 1ns / 1ps
module bmg_front import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] random_word_i,
  input  logic [30:0] thr_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output pair_t       push_data_o
);

  localparam logic [FRAC_W-1:0] KEEP_MASK =
    ~((FRAC_W'(1) << (FRAC_W - UNIFORM_BITS)) - FRAC_W'(1));

  logic              have_first_q, have_first_d;
  logic [FRAC_W-1:0] held_q, held_d;
  logic [FRAC_W-1:0] u;
  logic              accept;

  // top bits of the word as a 53-bit fraction
  assign u = random_word_i[63:64-FRAC_W] & KEEP_MASK;

  // a first value is always taken; a second one needs queue room
  assign in_ready_o   = !have_first_q || push_ready_i;
  assign push_valid_o = in_valid_i && have_first_q;
  assign push_data_o  = '{u1: held_q, ph: u[FRAC_W-1 -: PH_W]};
  assign accept       = in_valid_i && in_ready_o;

  // pair tracking and rejection of small first values
  always_comb begin
    have_first_d = have_first_q;
    held_d       = held_q;
    if (accept) begin
      if (!have_first_q) begin
        if (u >= {{(FRAC_W-31){1'b0}}, thr_i}) begin
          have_first_d = 1'b1;
          held_d       = u;
        end
      end else begin
        have_first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
    end else begin
      have_first_q <= have_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ----- rtl/bmg_queue.sv -----
`timescale 1ns / 1ps
`include "box_muller_gaussian_noise_top_macros.svh"
module bmg_queue import bmg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  pair_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output pair_t pop_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pair_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BMG_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count above depth")
  `BMG_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CNT_W'(1), "count did not rise")
  `BMG_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - CNT_W'(1), "count did not fall")

endmodule

// ----- rtl/bmg_back.sv -----
`timescale 1ns / 1ps
`include "box_muller_gaussian_noise_top_macros.svh"
module bmg_back import bmg_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  pair_t                           pop_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [OUT_FRAC_BITS+5:0] normal_value_o,
  output logic                            last_o
);

  localparam int OUT_W  = OUT_FRAC_BITS + 6;
  localparam int RND_SH = 54 - OUT_FRAC_BITS;
  localparam logic [60:0] RND_ADD = 61'd1 << (53 - OUT_FRAC_BITS);
  localparam logic [60:0] MAXMAG  = (61'd1 << (OUT_W - 1)) - 61'd1;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_NORM  = 5'd1;
  localparam logic [4:0] ST_LSQ   = 5'd2;
  localparam logic [4:0] ST_LUPD  = 5'd3;
  localparam logic [4:0] ST_LNM   = 5'd4;
  localparam logic [4:0] ST_LNU   = 5'd5;
  localparam logic [4:0] ST_SQRT  = 5'd6;
  localparam logic [4:0] ST_ANG   = 5'd7;
  localparam logic [4:0] ST_ANGX  = 5'd8;
  localparam logic [4:0] ST_X2    = 5'd9;
  localparam logic [4:0] ST_HMUL  = 5'd10;
  localparam logic [4:0] ST_HDIV  = 5'd11;
  localparam logic [4:0] ST_HSUB  = 5'd12;
  localparam logic [4:0] ST_SINF  = 5'd13;
  localparam logic [4:0] ST_SINU  = 5'd14;
  localparam logic [4:0] ST_OUTC  = 5'd15;
  localparam logic [4:0] ST_OUTCW = 5'd16;
  localparam logic [4:0] ST_OUTS  = 5'd17;
  localparam logic [4:0] ST_OUTSW = 5'd18;

  logic [4:0]          state_q, state_d;
  logic [FRAC_W-1:0]   norm_q, norm_d;
  logic [5:0]          sh_q, sh_d;
  logic [PH_W-1:0]     ph_q, ph_d;
  logic [31:0]         m_q, m_d;
  logic [23:0]         f_q, f_d;
  logic [4:0]          icnt_q, icnt_d;
  logic [RAD_W-1:0]    n_q, n_d;
  logic [ROOT_W+2:0]   rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [4:0]          scnt_q, scnt_d;
  logic [29:0]         x_q, x_d, x2_q, x2_d;
  logic [30:0]         t_q, t_d, c0_q, c0_d;
  logic [3:0]          kidx_q, kidx_d;
  logic [30:0]         trig_c_q, trig_c_d, trig_s_q, trig_s_d;
  logic                cneg_q, cneg_d, sneg_q, sneg_d;
  logic [63:0]         prod_q;
  logic [31:0]         mul_a, mul_b;
  logic                out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [OUT_W-1:0]    out_value_q, out_value_d;

  logic [32:0]         sq;
  logic [29:0]         l_val;
  logic [5:0]          sh1;
  logic [ROOT_W+2:0]   rem_sh, trial;
  logic [2:0]          octant;
  logic [29:0]         ang_a;
  logic [63:0]         q_full;
  logic [30:0]         t_new;
  logic [29:0]         s0;
  logic                swap, slot_free, neg_sel;
  logic [60:0]         rsum, mag_full;
  logic [OUT_W-1:0]    mag_w, fmt_val;

  assign pop_ready_o    = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign normal_value_o = out_value_q;
  assign last_o         = out_last_q;
  assign slot_free      = !out_valid_q || out_ready_i;

  // datapath helpers
  assign sq     = prod_q[63:31];
  assign sh1    = sh_q + 6'd1;
  assign l_val  = {sh1, 24'd0} - {6'd0, f_q};
  assign rem_sh = {rem_q[ROOT_W:0], n_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign octant = ph_q[31:29];
  assign ang_a  = octant[0] ? (30'h2000_0000 - {1'b0, ph_q[28:0]}) : {1'b0, ph_q[28:0]};
  assign q_full = prod_q >> (7'd30 + {3'd0, RSHIFT_TBL[kidx_q]});
  assign t_new  = ONE_Q30 - {1'b0, q_full[29:0]};
  assign s0     = prod_q[59:30];
  assign swap   = octant[0] ^ octant[1];

  // rounding, saturation and sign of the output sample
  assign neg_sel  = (state_q == ST_OUTSW) ? sneg_q : cneg_q;
  assign rsum     = {1'b0, prod_q[59:0]} + RND_ADD;
  assign mag_full = rsum >> RND_SH;
  always_comb begin
    if (mag_full > MAXMAG) begin
      mag_w = neg_sel ? OUT_W'(MAXMAG + 61'd1) : OUT_W'(MAXMAG);
    end else begin
      mag_w = mag_full[OUT_W-1:0];
    end
    fmt_val = neg_sel ? (~mag_w + OUT_W'(1)) : mag_w;
  end

  // operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LSQ: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      ST_LNM: begin
        mul_a = {2'd0, l_val};
        mul_b = LN2_Q32;
      end
      ST_ANG: begin
        mul_a = {2'd0, ang_a};
        mul_b = PI_HALF_Q30;
      end
      ST_ANGX: begin
        mul_a = {2'd0, prod_q[59:30]};
        mul_b = {2'd0, prod_q[59:30]};
      end
      ST_HMUL: begin
        mul_a = {2'd0, x2_q};
        mul_b = {1'b0, t_q};
      end
      ST_HDIV: begin
        mul_a = {2'd0, prod_q[59:30]};
        mul_b = RECIP_TBL[kidx_q];
      end
      ST_SINF: begin
        mul_a = {2'd0, x_q};
        mul_b = {1'b0, t_q};
      end
      ST_OUTC, ST_OUTCW: begin
        mul_a = {{(32-ROOT_W){1'b0}}, root_q};
        mul_b = {1'b0, trig_c_q};
      end
      ST_OUTS, ST_OUTSW: begin
        mul_a = {{(32-ROOT_W){1'b0}}, root_q};
        mul_b = {1'b0, trig_s_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    norm_d      = norm_q;
    sh_d        = sh_q;
    ph_d        = ph_q;
    m_d         = m_q;
    f_d         = f_q;
    icnt_d      = icnt_q;
    n_d         = n_q;
    rem_d       = rem_q;
    root_d      = root_q;
    scnt_d      = scnt_q;
    x_d         = x_q;
    x2_d        = x2_q;
    t_d         = t_q;
    c0_d        = c0_q;
    kidx_d      = kidx_q;
    trig_c_d    = trig_c_q;
    trig_s_d    = trig_s_q;
    cneg_d      = cneg_q;
    sneg_d      = sneg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_last_d  = out_last_q;
    out_value_d = out_value_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          // a zero first value takes the log of the smallest step
          norm_d  = (pop_data_i.u1 == '0) ? FRAC_W'(1) : pop_data_i.u1;
          ph_d    = pop_data_i.ph;
          sh_d    = '0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_q[FRAC_W-1]) begin
          m_d     = norm_q[FRAC_W-1 -: 32];
          f_d     = '0;
          icnt_d  = '0;
          state_d = ST_LSQ;
        end else begin
          norm_d = norm_q << 1;
          sh_d   = sh_q + 6'd1;
        end
      end
      ST_LSQ: begin
        state_d = ST_LUPD;
      end
      ST_LUPD: begin
        // one fraction bit of log2 per squaring
        if (sq[32]) begin
          m_d = sq[32:1];
          f_d = {f_q[22:0], 1'b1};
        end else begin
          m_d = sq[31:0];
          f_d = {f_q[22:0], 1'b0};
        end
        icnt_d  = icnt_q + 5'd1;
        state_d = (icnt_q == 5'd23) ? ST_LNM : ST_LSQ;
      end
      ST_LNM: begin
        state_d = ST_LNU;
      end
      ST_LNU: begin
        n_d     = {1'b0, prod_q[61:23], 16'd0};
        rem_d   = '0;
        root_d  = '0;
        scnt_d  = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        // two radicand bits per step
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        n_d     = n_q << 2;
        scnt_d  = scnt_q + 5'd1;
        state_d = (scnt_q == 5'(ROOT_W - 1)) ? ST_ANG : ST_SQRT;
      end
      ST_ANG: begin
        state_d = ST_ANGX;
      end
      ST_ANGX: begin
        x_d     = prod_q[59:30];
        state_d = ST_X2;
      end
      ST_X2: begin
        x2_d    = prod_q[59:30];
        t_d     = ONE_Q30;
        kidx_d  = '0;
        state_d = ST_HMUL;
      end
      ST_HMUL: begin
        state_d = ST_HDIV;
      end
      ST_HDIV: begin
        state_d = ST_HSUB;
      end
      ST_HSUB: begin
        if (kidx_q == COS_LAST) begin
          c0_d    = t_new;
          t_d     = ONE_Q30;
          kidx_d  = kidx_q + 4'd1;
          state_d = ST_HMUL;
        end else if (kidx_q == SIN_LAST) begin
          t_d     = t_new;
          state_d = ST_SINF;
        end else begin
          t_d     = t_new;
          kidx_d  = kidx_q + 4'd1;
          state_d = ST_HMUL;
        end
      end
      ST_SINF: begin
        state_d = ST_SINU;
      end
      ST_SINU: begin
        // octant folding to the full circle
        trig_c_d = swap ? {1'b0, s0} : c0_q;
        trig_s_d = swap ? c0_q : {1'b0, s0};
        cneg_d   = octant[1] ^ octant[2];
        sneg_d   = octant[2];
        state_d  = ST_OUTC;
      end
      ST_OUTC: begin
        state_d = ST_OUTCW;
      end
      ST_OUTCW: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          out_value_d = fmt_val;
          state_d     = ST_OUTS;
        end
      end
      ST_OUTS: begin
        state_d = ST_OUTSW;
      end
      ST_OUTSW: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_value_d = fmt_val;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= mul_a * mul_b;
    norm_q      <= norm_d;
    sh_q        <= sh_d;
    ph_q        <= ph_d;
    m_q         <= m_d;
    f_q         <= f_d;
    icnt_q      <= icnt_d;
    n_q         <= n_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    scnt_q      <= scnt_d;
    x_q         <= x_d;
    x2_q        <= x2_d;
    t_q         <= t_d;
    c0_q        <= c0_d;
    kidx_q      <= kidx_d;
    trig_c_q    <= trig_c_d;
    trig_s_q    <= trig_s_d;
    cneg_q      <= cneg_d;
    sneg_q      <= sneg_d;
    out_last_q  <= out_last_d;
    out_value_q <= out_value_d;
  end

  `BMG_ASSERT(a_norm_nonzero, (state_q != ST_NORM) || (norm_q != '0), "normalizing a zero value")
  `BMG_ASSERT(a_sqrt_rem, (state_q != ST_SQRT) || (rem_q <= {1'b0, root_q, 1'b0}), "root remainder too large")
  `BMG_ASSERT(a_cos_then_sin, !(out_valid_q && !out_last_q) || (state_q == ST_OUTS) || (state_q == ST_OUTSW), "cosine shown without sine pending")

endmodule

// ----- rtl/box_muller_gaussian_noise_top.sv -----
`timescale 1ns / 1ps
// Gaussian noise generator from uniform random words (Box-Muller).
// Input channel: in_valid_i / in_ready_o with random_word_i, one 64-bit word per request.
// Words pair up: the first of a pair is dropped when below reject_threshold, else held;
// the second completes the pair and yields two results on the output channel.
// Output channel: out_valid_o / out_ready_i with normal_value_o (signed Q5.16 at
// default size) and last_o, which is low on the cosine and high on the sine result.
// A first word is always taken; a second needs room in the pair queue (two entries).
// Each pair holds the back end through normalization, the log2 squaring loop, the
// square root and the sine/cosine series, all sharing one registered 32x32 multiplier.
// The cosine result is shown first and the sine result after it.
// A stalled receiver holds the result register; the back end waits, the queue
// fills and then in_ready_o drops for second words.
// Reset clears the pending first value, the queue and the output register,
// and sets reject_threshold to 2. The threshold is written over the APB port
// at address 0; the user must write it only while the block is idle (not enforced).
module box_muller_gaussian_noise_top import bmg_pkg::*; #(
  parameter int UNIFORM_BITS  = UNIFORM_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [63:0]                     random_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [OUT_FRAC_BITS+5:0] normal_value_o,
  output logic                            last_o
);

  localparam logic REG_THRESHOLD = 1'b0;

  logic [30:0] thr_q, thr_d;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  pair_t       push_data, pop_data;

  // register write and read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {1'b0, thr_q} : 32'd0;

  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
      thr_d = pwdata[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  bmg_front #(
    .UNIFORM_BITS(UNIFORM_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .random_word_i(random_word_i),
    .thr_i        (thr_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bmg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  bmg_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .normal_value_o(normal_value_o),
    .last_o        (last_o)
  );

endmodule
